// File: rtl/core/grouped_prefix_window_sums_defines.svh
// Assertion macros for the grouped prefix window sums block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef GROUPED_PREFIX_WINDOW_SUMS_DEFINES_SVH
`define GROUPED_PREFIX_WINDOW_SUMS_DEFINES_SVH

// Same-cycle implication, off while in reset
`define GPWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define GPWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gpws_pkg.sv
// Shared types, constants and helpers for the grouped prefix window sums block.
// No dependencies.
`default_nettype none
package gpws_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_PERIODS = 10;
  localparam int ROW_W       = 10;
  localparam int PER_W       = 4;
  localparam int CNT_W       = 11;
  localparam int VAL_W       = 32;
  localparam int GRP_W       = 16;
  localparam int SUM_W       = 48;
  localparam int IDX_W       = 6;
  localparam int CELLS       = MAX_ROWS * MAX_PERIODS;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int DESC_W      = ROW_W + GRP_W;

  // Action codes
  localparam logic [1:0] ACT_LOAD_VAL  = 2'd0;
  localparam logic [1:0] ACT_LOAD_DESC = 2'd1;
  localparam logic [1:0] ACT_COMPUTE   = 2'd2;
  localparam logic [1:0] ACT_EMIT      = 2'd3;

  // Register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_PERIOD_COUNT = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] n;  // rows in use
    logic [PER_W-1:0] t;  // periods in use
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [PER_W-1:0] period;
    logic [VAL_W-1:0] value;
    logic [ROW_W-1:0] source_row;
    logic [GRP_W-1:0] group_id;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [PER_W-1:0] window_start;
    logic [PER_W-1:0] window_length;
    logic [IDX_W-1:0] window_index;
    logic [SUM_W-1:0] sum;
    logic             last;
  } res_t;

  // Flat cell address of (row, period)
  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                 input logic [PER_W-1:0] per);
    cell_addr = CELL_W'(row) * CELL_W'(MAX_PERIODS) + CELL_W'(per);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/gpws_front.sv
// Front end: accepts items, drops those with no effect, queues commands.
// Depends on gpws_pkg.
`default_nettype none
module gpws_front
  import gpws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       in_action,
  input  wire logic [ROW_W-1:0] in_row,
  input  wire logic [PER_W-1:0] in_period,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic [ROW_W-1:0] in_source_row,
  input  wire logic [GRP_W-1:0] in_group_id,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  wire logic             cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       do_push;
  logic       do_pop;
  cmd_t       item;

  // Classify: drop items that change nothing
  always_comb begin
    item = '{op: in_action, row: in_row, period: in_period, value: in_value,
             source_row: in_source_row, group_id: in_group_id};
    keep = 1'b1;
    case (in_action)
      ACT_LOAD_VAL:  keep = (in_period < PER_W'(MAX_PERIODS));
      ACT_LOAD_DESC: keep = 1'b1;
      ACT_COMPUTE:   keep = (cfg.n != '0) && (cfg.t != '0);
      default:       keep = ({1'b0, in_row} < cfg.n) && (cfg.t != '0);
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = push && !full && keep;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/gpws_back.sv
// Back end: stores, prefix computation, window emission and result queue.
// Depends on gpws_pkg.
`default_nettype none
module gpws_back
  import gpws_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_C_DESC = 3'd1;
  localparam logic [2:0] S_C_VAL  = 3'd2;
  localparam logic [2:0] S_C_ACC  = 3'd3;
  localparam logic [2:0] S_E_RD   = 3'd4;
  localparam logic [2:0] S_E_OUT  = 3'd5;

  // Memories
  logic [VAL_W-1:0]  value_mem_r  [CELLS];
  logic [DESC_W-1:0] desc_mem_r   [MAX_ROWS];
  logic [SUM_W-1:0]  prefix_mem_r [CELLS];
  logic [VAL_W-1:0]  v_rd_r;
  logic [DESC_W-1:0] d_rd_r;
  logic [SUM_W-1:0]  p_rd_r;

  logic              v_we, v_re, d_we, d_re, p_we, p_re;
  logic [CELL_W-1:0] v_wa, v_ra, p_wa, p_ra;
  logic [SUM_W-1:0]  p_wd;

  logic [2:0]        st_r, st_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [PER_W-1:0]  col_r, col_nxt;
  logic [SUM_W-1:0]  run_r, run_nxt;
  logic [GRP_W-1:0]  prev_grp_r, prev_grp_nxt, grp_cur_r, grp_cur_nxt;
  logic [ROW_W-1:0]  erow_r, erow_nxt;
  logic [PER_W-1:0]  s_r, s_nxt, len_r, len_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W-1:0]  add, win_sum;

  // Result queue
  res_t       oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       o_push, o_pop, o_full;
  res_t       o_item;

  assign o_full = (ocnt_r == 2'd2);
  assign empty  = (ocnt_r == 2'd0);
  assign o_pop  = pop && !empty;
  assign res    = oq_r[orp_r];

  assign add     = {{(SUM_W-VAL_W){v_rd_r[VAL_W-1]}}, v_rd_r};
  assign win_sum = acc_r + p_rd_r;

  // Sequencer
  always_comb begin
    st_nxt       = st_r;
    r_nxt        = r_r;
    col_nxt      = col_r;
    run_nxt      = run_r;
    prev_grp_nxt = prev_grp_r;
    grp_cur_nxt  = grp_cur_r;
    erow_nxt     = erow_r;
    s_nxt        = s_r;
    len_nxt      = len_r;
    k_nxt        = k_r;
    acc_nxt      = acc_r;
    cmd_pop      = 1'b0;
    v_we = 1'b0; v_re = 1'b0; d_we = 1'b0; d_re = 1'b0; p_we = 1'b0; p_re = 1'b0;
    v_wa = cell_addr(cmd.row, cmd.period);
    v_ra = cell_addr(d_rd_r[ROW_W-1:0], col_r);
    p_wa = cell_addr(r_r, col_r);
    p_ra = cell_addr(erow_r, s_r + len_r - PER_W'(1));
    p_wd = run_r;
    o_push = 1'b0;
    o_item = '{out_row: erow_r, window_start: s_r, window_length: len_r,
               window_index: k_r, sum: win_sum,
               last: (s_r == cfg.t - PER_W'(1))};
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            ACT_LOAD_VAL:  v_we = 1'b1;
            ACT_LOAD_DESC: d_we = 1'b1;
            ACT_COMPUTE: begin
              r_nxt   = '0;
              col_nxt = '0;
              st_nxt  = S_C_DESC;
            end
            ACT_EMIT: begin
              erow_nxt = cmd.row;
              s_nxt    = '0;
              len_nxt  = PER_W'(1);
              k_nxt    = '0;
              acc_nxt  = '0;
              st_nxt   = S_E_RD;
            end
          endcase
        end
      end
      S_C_DESC: begin
        d_re   = 1'b1;
        st_nxt = S_C_VAL;
      end
      S_C_VAL: begin
        v_re        = 1'b1;
        grp_cur_nxt = d_rd_r[DESC_W-1:ROW_W];
        st_nxt      = S_C_ACC;
      end
      S_C_ACC: begin
        // Restart at the first row and on a group change
        run_nxt = ((r_r == '0) || (grp_cur_r != prev_grp_r)) ? add : run_r + add;
        p_we         = 1'b1;
        p_wd         = run_nxt;
        prev_grp_nxt = grp_cur_r;
        st_nxt       = S_C_DESC;
        if ({1'b0, r_r} == cfg.n - CNT_W'(1)) begin
          r_nxt = '0;
          if (col_r == cfg.t - PER_W'(1)) st_nxt = S_IDLE;
          else col_nxt = col_r + PER_W'(1);
        end else begin
          r_nxt = r_r + ROW_W'(1);
        end
      end
      S_E_RD: begin
        p_re   = 1'b1;
        st_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (!o_full) begin
          o_push = 1'b1;
          k_nxt  = k_r + IDX_W'(1);
          st_nxt = S_E_RD;
          if (s_r + len_r == cfg.t) begin
            if (s_r == cfg.t - PER_W'(1)) st_nxt = S_IDLE;
            s_nxt   = s_r + PER_W'(1);
            len_nxt = PER_W'(1);
            acc_nxt = '0;
          end else begin
            len_nxt = len_r + PER_W'(1);
            acc_nxt = win_sum;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (v_we) value_mem_r[v_wa] <= cmd.value;
    if (v_re) v_rd_r <= value_mem_r[v_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) desc_mem_r[cmd.row] <= {cmd.group_id, cmd.source_row};
    if (d_re) d_rd_r <= desc_mem_r[r_r];
  end

  always_ff @(posedge clk) begin
    if (p_we) prefix_mem_r[p_wa] <= p_wd;
    if (p_re) p_rd_r <= prefix_mem_r[p_ra];
  end

  // Working registers
  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    col_r      <= col_nxt;
    run_r      <= run_nxt;
    prev_grp_r <= prev_grp_nxt;
    grp_cur_r  <= grp_cur_nxt;
    erow_r     <= erow_nxt;
    s_r        <= s_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    if (o_push) oq_r[owp_r] <= o_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      st_r   <= st_nxt;
      owp_r  <= owp_r ^ o_push;
      orp_r  <= orp_r ^ o_pop;
      ocnt_r <= ocnt_r + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/grouped_prefix_window_sums.sv
// Top level of the grouped prefix window sums block: register port and assertions.
// Depends on gpws_pkg, gpws_front, gpws_back and grouped_prefix_window_sums_defines.svh.
//
// Loads are written in the idle state of the back end. Compute walks every row of every period
// column through the descriptor, value and prefix memories in turn, in the states S_C_DESC,
// S_C_VAL and S_C_ACC. Emit reads one stored prefix per window in S_E_RD and queues the window
// in S_E_OUT, which waits while the result side holds off; a row gives T*(T+1)/2 windows. A
// two-entry command queue lets the next item be taken while the back end works, and a two-entry
// result queue holds finished windows. The stores are not cleared by reset; read only entries
// that have been written.
`default_nettype none
`include "grouped_prefix_window_sums_defines.svh"
module grouped_prefix_window_sums
  import gpws_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       in_action,
  input  wire logic [ROW_W-1:0] in_row,
  input  wire logic [PER_W-1:0] in_period,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic [ROW_W-1:0] in_source_row,
  input  wire logic [GRP_W-1:0] in_group_id,
  output logic                  empty,
  input  wire logic             pop,
  output logic [ROW_W-1:0]      out_row,
  output logic [PER_W-1:0]      out_window_start,
  output logic [PER_W-1:0]      out_window_length,
  output logic [IDX_W-1:0]      out_window_index,
  output logic signed [SUM_W-1:0] out_sum,
  output logic                  out_last,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [CNT_W-1:0] row_count_r;
  logic [PER_W-1:0] period_count_r;
  logic             wr_en;
  cfg_t             cfg;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  res_t             res;

  // Register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= CNT_W'(1);
      period_count_r <= PER_W'(1);
    end else if (wr_en) begin
      if (paddr[2] == REG_ROW_COUNT) row_count_r <= pwdata[CNT_W-1:0];
      else period_count_r <= pwdata[PER_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ROW_COUNT) prdata = {{(32-CNT_W){1'b0}}, row_count_r};
    else prdata = {{(32-PER_W){1'b0}}, period_count_r};
  end

  // Clamp to the sizes held
  assign cfg.n = (row_count_r > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_r;
  assign cfg.t = (period_count_r > PER_W'(MAX_PERIODS)) ? PER_W'(MAX_PERIODS)
                                                        : period_count_r;

  gpws_front u_front (
    .clk, .rst_n, .cfg, .push, .full,
    .in_action, .in_row, .in_period, .in_value, .in_source_row, .in_group_id,
    .cmd_valid, .cmd, .cmd_pop
  );

  gpws_back u_back (
    .clk, .rst_n, .cfg, .cmd_valid, .cmd, .cmd_pop, .empty, .pop, .res
  );

  assign out_row           = res.out_row;
  assign out_window_start  = res.window_start;
  assign out_window_length = res.window_length;
  assign out_window_index  = res.window_index;
  assign out_sum           = res.sum;
  assign out_last          = res.last;

  // Checks
  `GPWS_ASSERT_NOW(a_len_nonzero, !empty, out_window_length != '0, "zero-length window")
  `GPWS_ASSERT_NOW(a_win_fits, !empty,
    ({1'b0, out_window_start} + {1'b0, out_window_length}) <= {1'b0, cfg.t},
    "window beyond periods in use")
  `GPWS_ASSERT_NOW(a_row_in_use, !empty, {1'b0, out_row} < cfg.n, "emitted row not in use")
  `GPWS_ASSERT_NEXT(a_first_after_last, pop && !empty && out_last,
    empty || out_window_index == '0,
    "result order broken")

endmodule
`default_nettype wire
